// ===== rtl/i8dqmm_pkg.sv =====
// Shared types and constants of the dynamic int8 quantized matrix multiply.
package i8dqmm_pkg;

    // Action codes carried in s_tuser.
    typedef enum logic [1:0] {
        ACT_LOAD_A  = 2'd0,
        ACT_LOAD_B  = 2'd1,
        ACT_COMPUTE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ROW_COUNT    = 2'd0,
        CFG_INNER_COUNT  = 2'd1,
        CFG_COL_COUNT    = 2'd2,
        CFG_WEIGHT_SCALE = 2'd3
    } cfg_index_t;

    // Divisor width of the shared divider: twice the largest |a| fits in 17 bits.
    localparam int DIVISOR_W = 17;

    // Quantization levels of one sign of an int8 value.
    localparam int QUANT_LEVELS = 127;

endpackage

// ===== rtl/i8dqmm_divider.sv =====
// Shared shift-and-subtract divider, one quotient bit per cycle.
module i8dqmm_divider #(
    parameter int NUM_W = 41
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [NUM_W-1:0]                 dividend,
    input  logic [i8dqmm_pkg::DIVISOR_W-1:0] divisor,
    output logic                             done,
    output logic [NUM_W-1:0]                 quotient
);

    localparam int DW  = i8dqmm_pkg::DIVISOR_W;
    localparam int CNW = $clog2(NUM_W + 1);

    logic [DW-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [CNW-1:0]   cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DW:0]      trial;
    logic             fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        fits      = (trial >= {1'b0, divisor});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNW'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/int8_dynamic_quant_matmul.sv =====
// Top level of the dynamic int8 quantized matrix multiply.
//
// Load beats (s_tuser = 0 for an A element in Q8.8, 1 for an int8 B element) are taken one
// per cycle and fill the A and B stores in row-major order; loads beyond MAX_DIM*MAX_DIM
// entries are dropped. A compute beat (s_tuser = 2) runs the whole job, and the input stays
// not ready until the last result beat has been taken. A scan first finds the largest |a|.
// Each A element is then quantized in the shared serial divider, or written as zero when A
// is all zero; NUM_W, the width of its dividend, is 41+log2(MAX_DIM) rounded up. Each result
// element then runs a multiply-accumulate over inner_count products, the multiplications by
// the largest |a| and the weight scale, and a round and divide by 127, followed by its output
// beat, which holds for as long as m_tready is low. The division by 127 folds base-128
// digits (128 = 127 + 1) with one shift and add per cycle. Results leave row-major in signed
// Q24.8 at a weight scale of 65536, with m_tlast on the final element. A beat with
// s_tuser = 3 is ignored. Configuration registers must only be written while no compute job
// is running, since the weight scale is read live during the job.
module int8_dynamic_quant_matmul #(
    parameter int MAX_DIM = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wdata,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // a_value [15:0], b_value [23:16]
    input  logic [1:0]  s_tuser,   // action [1:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // product_value [31:0], out_row [34:32], out_col [37:35]
    output logic        m_tlast
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int IDXW   = $clog2(DEPTH + 1);
    localparam int CW     = $clog2(MAX_DIM + 1);
    localparam int SUM_W  = 16 + $clog2(MAX_DIM);
    localparam int P1_W   = SUM_W + 16;
    localparam int P2_W   = SUM_W + 40;
    localparam int NUM_W  = P2_W + 1 - 16;
    localparam int DW     = i8dqmm_pkg::DIVISOR_W;
    localparam logic [P2_W:0] ROUND_HALF = (P2_W + 1)'(i8dqmm_pkg::QUANT_LEVELS) << 15;

    // The sequencer walks scan, quantize, multiply-accumulate, scale and emit.
    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_SCAN_RD  = 13'b0000000000010,
        ST_SCAN_CMP = 13'b0000000000100,
        ST_QNT_RD   = 13'b0000000001000,
        ST_QNT_GO   = 13'b0000000010000,
        ST_QNT_WAIT = 13'b0000000100000,
        ST_DOT_RD   = 13'b0000001000000,
        ST_DOT_ACC  = 13'b0000010000000,
        ST_MUL1     = 13'b0000100000000,
        ST_MUL2     = 13'b0001000000000,
        ST_DIV_GO   = 13'b0010000000000,
        ST_DIV_WAIT = 13'b0100000000000,
        ST_EMIT     = 13'b1000000000000
    } state_t;

    function automatic logic [CW-1:0] clamp_count(input logic [3:0] c);
        if (c == 4'd0) begin
            return CW'(1);
        end else if (int'(c) > MAX_DIM) begin
            return CW'(MAX_DIM);
        end else begin
            return CW'(c);
        end
    endfunction

    // Configuration registers.
    logic [3:0]  row_count_reg, inner_count_reg, col_count_reg;
    logic [23:0] weight_scale_reg;

    // Stores.
    logic signed [15:0] a_mem [DEPTH];
    logic signed [7:0]  b_mem [DEPTH];
    logic signed [7:0]  q_mem [DEPTH];
    logic signed [15:0] a_rd_reg;
    logic signed [7:0]  b_rd_reg, q_rd_reg;
    logic [AW-1:0]      a_rd_addr, b_rd_addr, q_rd_addr;
    logic               a_wr_en, b_wr_en, q_wr_en;
    logic signed [7:0]  q_wr_data;

    // Sequencer state.
    state_t          state_reg, state_next;
    logic [IDXW-1:0] a_ld_reg, a_ld_next, b_ld_reg, b_ld_next;
    logic [IDXW-1:0] idx_reg, idx_next, total_reg, total_next;
    logic [CW-1:0]   rows_reg, rows_next, inner_reg, inner_next, cols_reg, cols_next;
    logic [CW-1:0]   r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic [IDXW-1:0] row_base_reg, row_base_next, b_ptr_reg, b_ptr_next;
    logic [15:0]     max_reg, max_next;
    logic            sign_reg, sign_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic [P1_W-1:0] p1_reg, p1_next;
    logic [P2_W-1:0] p2_reg, p2_next;
    logic            neg_reg, neg_next;
    logic [NUM_W-1:0] red_reg, red_next, quo127_reg, quo127_next;
    logic [31:0]     out_value_reg, out_value_next;
    logic [2:0]      out_row_reg, out_row_next, out_col_reg, out_col_next;
    logic            out_last_reg, out_last_next;
    logic            m_valid_reg, m_valid_next;

    // Shared divider hookup.
    logic             div_start;
    logic [NUM_W-1:0] div_dividend;
    logic [DW-1:0]    div_divisor;
    logic             div_done;
    logic [NUM_W-1:0] div_quotient;

    // Datapath helpers.
    logic [15:0]        a_mag;
    logic signed [15:0] dot_prod;
    logic [SUM_W-1:0]   acc_mag;
    logic [P2_W:0]      rounded;
    logic [NUM_W-1:0]   red_hi, scaled;
    logic [IDXW-1:0]    q_addr_full;
    logic [7:0]         q_mag;
    logic               s_fire, m_fire, last_elem;
    i8dqmm_pkg::action_t action;

    assign action    = i8dqmm_pkg::action_t'(s_tuser);
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_valid_reg && m_tready;

    assign a_mag       = a_rd_reg[15] ? 16'(~a_rd_reg + 16'sd1) : 16'(a_rd_reg);
    assign dot_prod    = q_rd_reg * b_rd_reg;
    assign acc_mag     = acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
    assign rounded     = {1'b0, p2_reg} + ROUND_HALF;
    assign q_addr_full = row_base_reg + IDXW'(k_reg);
    assign q_mag       = div_quotient[7:0];
    assign last_elem   = (r_reg == rows_reg - 1'b1) && (c_reg == cols_reg - 1'b1);

    // A value of 128*H + L equals 127*H + (H + L), so each step moves H into the quotient
    // and keeps H + L as the remainder still to divide. Below 128 only 127 itself adds one.
    assign red_hi = NUM_W'(red_reg[NUM_W-1:7]);
    assign scaled = quo127_reg + NUM_W'(red_reg[6:0] == 7'd127);

    assign a_rd_addr = idx_reg[AW-1:0];
    assign q_rd_addr = q_addr_full[AW-1:0];
    assign b_rd_addr = b_ptr_reg[AW-1:0];

    // Memories: loads write A and B, the quantize pass writes Q.
    always_ff @(posedge aclk) begin
        if (a_wr_en) begin
            a_mem[a_ld_reg[AW-1:0]] <= s_tdata[15:0];
        end
        if (b_wr_en) begin
            b_mem[b_ld_reg[AW-1:0]] <= s_tdata[23:16];
        end
        if (q_wr_en) begin
            q_mem[idx_reg[AW-1:0]] <= q_wr_data;
        end
        a_rd_reg <= a_mem[a_rd_addr];
        b_rd_reg <= b_mem[b_rd_addr];
        q_rd_reg <= q_mem[q_rd_addr];
    end

    i8dqmm_divider #(
        .NUM_W (NUM_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next     = state_reg;
        a_ld_next      = a_ld_reg;
        b_ld_next      = b_ld_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        rows_next      = rows_reg;
        inner_next     = inner_reg;
        cols_next      = cols_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        row_base_next  = row_base_reg;
        b_ptr_next     = b_ptr_reg;
        max_next       = max_reg;
        sign_next      = sign_reg;
        acc_next       = acc_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        neg_next       = neg_reg;
        red_next       = red_reg;
        quo127_next    = quo127_reg;
        out_value_next = out_value_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;
        m_valid_next   = m_valid_reg;
        a_wr_en        = 1'b0;
        b_wr_en        = 1'b0;
        q_wr_en        = 1'b0;
        q_wr_data      = '0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (action)
                        i8dqmm_pkg::ACT_LOAD_A: begin
                            if (a_ld_reg != IDXW'(DEPTH)) begin
                                a_wr_en   = 1'b1;
                                a_ld_next = a_ld_reg + 1'b1;
                            end
                        end
                        i8dqmm_pkg::ACT_LOAD_B: begin
                            if (b_ld_reg != IDXW'(DEPTH)) begin
                                b_wr_en   = 1'b1;
                                b_ld_next = b_ld_reg + 1'b1;
                            end
                        end
                        i8dqmm_pkg::ACT_COMPUTE: begin
                            rows_next  = clamp_count(row_count_reg);
                            inner_next = clamp_count(inner_count_reg);
                            cols_next  = clamp_count(col_count_reg);
                            total_next = IDXW'(clamp_count(row_count_reg))
                                         * IDXW'(clamp_count(inner_count_reg));
                            idx_next   = '0;
                            max_next   = '0;
                            state_next = ST_SCAN_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (a_mag > max_reg) begin
                    max_next = a_mag;
                end
                if (idx_reg + 1'b1 == total_reg) begin
                    idx_next   = '0;
                    state_next = ST_QNT_RD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_QNT_RD: begin
                state_next = ST_QNT_GO;
            end
            ST_QNT_GO: begin
                sign_next = a_rd_reg[15];
                if (max_reg == 16'd0) begin
                    // With an all-zero A every quantized value is zero.
                    q_wr_en   = 1'b1;
                    q_wr_data = '0;
                    if (idx_reg + 1'b1 == total_reg) begin
                        r_next        = '0;
                        c_next        = '0;
                        k_next        = '0;
                        row_base_next = '0;
                        b_ptr_next    = '0;
                        acc_next      = '0;
                        state_next    = ST_DOT_RD;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_QNT_RD;
                    end
                end else begin
                    // q = (2*|a|*127 + M) / (2*M), rounding half away from zero.
                    div_start    = 1'b1;
                    div_dividend = NUM_W'(23'(a_mag) * 23'(2 * i8dqmm_pkg::QUANT_LEVELS)
                                          + 23'(max_reg));
                    div_divisor  = {max_reg, 1'b0};
                    state_next   = ST_QNT_WAIT;
                end
            end
            ST_QNT_WAIT: begin
                div_divisor = {max_reg, 1'b0};
                if (div_done) begin
                    q_wr_en   = 1'b1;
                    q_wr_data = sign_reg ? 8'(-q_mag) : q_mag;
                    if (idx_reg + 1'b1 == total_reg) begin
                        r_next        = '0;
                        c_next        = '0;
                        k_next        = '0;
                        row_base_next = '0;
                        b_ptr_next    = '0;
                        acc_next      = '0;
                        state_next    = ST_DOT_RD;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_QNT_RD;
                    end
                end
            end
            ST_DOT_RD: begin
                state_next = ST_DOT_ACC;
            end
            ST_DOT_ACC: begin
                acc_next   = acc_reg + SUM_W'(dot_prod);
                b_ptr_next = b_ptr_reg + IDXW'(cols_reg);
                if (k_reg == inner_reg - 1'b1) begin
                    state_next = ST_MUL1;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_DOT_RD;
                end
            end
            ST_MUL1: begin
                neg_next   = acc_reg[SUM_W-1];
                p1_next    = P1_W'(acc_mag) * P1_W'(max_reg);
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                p2_next    = P2_W'(p1_reg) * P2_W'(weight_scale_reg);
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                // Rounded scale by 1/(127*2^16): add half, drop 16 bits, divide by 127.
                red_next    = rounded[P2_W:16];
                quo127_next = '0;
                state_next  = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (red_hi != '0) begin
                    quo127_next = quo127_reg + red_hi;
                    red_next    = red_hi + NUM_W'(red_reg[6:0]);
                end else begin
                    if (!neg_reg) begin
                        out_value_next = (|scaled[NUM_W-1:31]) ? 32'h7FFF_FFFF
                                                               : scaled[31:0];
                    end else if ((|scaled[NUM_W-1:32])
                                 || (scaled[31] && (|scaled[30:0]))) begin
                        out_value_next = 32'h8000_0000;
                    end else begin
                        out_value_next = 32'd0 - scaled[31:0];
                    end
                    out_row_next  = 3'(r_reg);
                    out_col_next  = 3'(c_reg);
                    out_last_next = last_elem;
                    m_valid_next  = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_fire) begin
                    m_valid_next = 1'b0;
                    k_next       = '0;
                    acc_next     = '0;
                    if (last_elem) begin
                        a_ld_next  = '0;
                        b_ld_next  = '0;
                        state_next = ST_IDLE;
                    end else if (c_reg == cols_reg - 1'b1) begin
                        c_next        = '0;
                        r_next        = r_reg + 1'b1;
                        row_base_next = row_base_reg + IDXW'(inner_reg);
                        b_ptr_next    = '0;
                        state_next    = ST_DOT_RD;
                    end else begin
                        c_next     = c_reg + 1'b1;
                        b_ptr_next = IDXW'(c_reg + 1'b1);
                        state_next = ST_DOT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            a_ld_reg         <= '0;
            b_ld_reg         <= '0;
            max_reg          <= '0;
            m_valid_reg      <= 1'b0;
            row_count_reg    <= 4'd8;
            inner_count_reg  <= 4'd8;
            col_count_reg    <= 4'd8;
            weight_scale_reg <= 24'd65536;
        end else begin
            state_reg   <= state_next;
            a_ld_reg    <= a_ld_next;
            b_ld_reg    <= b_ld_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (i8dqmm_pkg::cfg_index_t'(cfg_addr))
                    i8dqmm_pkg::CFG_ROW_COUNT:    row_count_reg    <= cfg_wdata[3:0];
                    i8dqmm_pkg::CFG_INNER_COUNT:  inner_count_reg  <= cfg_wdata[3:0];
                    i8dqmm_pkg::CFG_COL_COUNT:    col_count_reg    <= cfg_wdata[3:0];
                    i8dqmm_pkg::CFG_WEIGHT_SCALE: weight_scale_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        idx_reg       <= idx_next;
        total_reg     <= total_next;
        rows_reg      <= rows_next;
        inner_reg     <= inner_next;
        cols_reg      <= cols_next;
        r_reg         <= r_next;
        c_reg         <= c_next;
        k_reg         <= k_next;
        row_base_reg  <= row_base_next;
        b_ptr_reg     <= b_ptr_next;
        sign_reg      <= sign_next;
        acc_reg       <= acc_next;
        p1_reg        <= p1_next;
        p2_reg        <= p2_next;
        neg_reg       <= neg_next;
        red_reg       <= red_next;
        quo127_reg    <= quo127_next;
        out_value_reg <= out_value_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_col_reg, out_row_reg, out_value_reg};
    assign m_tlast  = out_last_reg;

endmodule
